// ----- src/flr_pkg.sv -----
// ----------------------------------------------------------------------------
// flr_pkg
// Shared types and constants for the page framebuffer line rasterizer.
// ----------------------------------------------------------------------------
package flr_pkg;

    localparam int PAGE_ROWS = 8;
    localparam int IN_COORD_W = 12;
    localparam int INDEX_W = 10;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LINE  = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef struct packed {
        logic pix_valid;
        logic last;
    } t_walk_stat;

endpackage

// ----- src/flr_ram.sv -----
// ----------------------------------------------------------------------------
// flr_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module flr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/flr_walker.sv -----
// ----------------------------------------------------------------------------
// flr_walker
// Bresenham line walker: orders the endpoints, then emits one pixel a cycle.
// ----------------------------------------------------------------------------
module flr_walker #(
    parameter int CW = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [CW-1:0]  i_ax,
    input  logic signed [CW-1:0]  i_ay,
    input  logic signed [CW-1:0]  i_bx,
    input  logic signed [CW-1:0]  i_by,
    output flr_pkg::t_walk_stat   o_stat,
    output logic signed [CW-1:0]  o_pix_x,
    output logic signed [CW-1:0]  o_pix_y
);
    import flr_pkg::*;

    localparam int DW = CW + 1;
    localparam int EW = CW + 2;

    typedef enum logic [1:0] {
        W_IDLE,
        W_ORDER,
        W_PREP,
        W_STEP
    } t_wstate;

    t_wstate r_state;

    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [CW-1:0] r_amaj, r_amin, r_bmaj, r_bmin;
    logic                 r_steep;
    logic signed [EW-1:0] r_dx, r_dy, r_err;
    logic                 r_neg;

    logic signed [DW-1:0] dxs, dys, adx, ady;
    logic                 steep;
    logic signed [CW-1:0] ma, na, mb, nb;
    logic signed [DW-1:0] dmaj, dmin, admin;
    logic signed [EW-1:0] e1;
    logic                 last;

    always_comb begin
        dxs = DW'(r_bx) - DW'(r_ax);
        dys = DW'(r_by) - DW'(r_ay);
        adx = (dxs < 0) ? -dxs : dxs;
        ady = (dys < 0) ? -dys : dys;
        steep = ady > adx;
        ma = steep ? r_ay : r_ax;
        na = steep ? r_ax : r_ay;
        mb = steep ? r_by : r_bx;
        nb = steep ? r_bx : r_by;
        dmaj = DW'(r_bmaj) - DW'(r_amaj);
        dmin = DW'(r_bmin) - DW'(r_amin);
        admin = (dmin < 0) ? -dmin : dmin;
        e1 = r_err - r_dy;
        last = r_amaj == r_bmaj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else begin
            case (r_state)
                W_IDLE: begin
                    if (i_start) begin
                        r_ax <= i_ax;
                        r_ay <= i_ay;
                        r_bx <= i_bx;
                        r_by <= i_by;
                        r_state <= W_ORDER;
                    end
                end
                W_ORDER: begin
                    r_steep <= steep;
                    if (ma > mb) begin
                        r_amaj <= mb;
                        r_amin <= nb;
                        r_bmaj <= ma;
                        r_bmin <= na;
                    end else begin
                        r_amaj <= ma;
                        r_amin <= na;
                        r_bmaj <= mb;
                        r_bmin <= nb;
                    end
                    r_state <= W_PREP;
                end
                W_PREP: begin
                    r_dx <= EW'(dmaj);
                    r_dy <= EW'(admin);
                    r_err <= EW'(dmaj) >>> 1;
                    r_neg <= r_amin > r_bmin;
                    r_state <= W_STEP;
                end
                W_STEP: begin
                    if (last) begin
                        r_state <= W_IDLE;
                    end else begin
                        r_amaj <= r_amaj + CW'(1);
                        if (e1 < 0) begin
                            r_amin <= r_neg ? r_amin - CW'(1) : r_amin + CW'(1);
                            r_err <= e1 + r_dx;
                        end else begin
                            r_err <= e1;
                        end
                    end
                end
                default: begin
                    r_state <= W_IDLE;
                end
            endcase
        end
    end

    assign o_stat.pix_valid = r_state == W_STEP;
    assign o_stat.last = last;
    assign o_pix_x = r_steep ? r_amin : r_amaj;
    assign o_pix_y = r_steep ? r_amaj : r_amin;

endmodule

// ----- src/framebuffer_line_rasterizer_core.sv -----
// The line walker steps one pixel per cycle. One item is in work at a time;
// the result waits in an output register. Reset is synchronous; after
// reset the store is swept to zero, one byte a cycle, with input stalled
// (DEPTH = SCREEN_W * ceil(SCREEN_H / 8) bytes).
// ----------------------------------------------------------------------------
// framebuffer_line_rasterizer_core
// Page-organized monochrome framebuffer with clear, line draw and byte read.
// ----------------------------------------------------------------------------
module framebuffer_line_rasterizer_core #(
    parameter int SCREEN_W = 128,
    parameter int SCREEN_H = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_op,
    input  logic signed [flr_pkg::IN_COORD_W-1:0] i_start_x,
    input  logic signed [flr_pkg::IN_COORD_W-1:0] i_start_y,
    input  logic signed [flr_pkg::IN_COORD_W-1:0] i_end_x,
    input  logic signed [flr_pkg::IN_COORD_W-1:0] i_end_y,
    input  logic                               i_ink,
    input  logic [flr_pkg::INDEX_W-1:0]        i_byte_index,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_served_op,
    output logic [7:0]                         o_read_byte
);
    import flr_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DEPTH = SCREEN_W * ((SCREEN_H + PAGE_ROWS - 1) / PAGE_ROWS);
    localparam int AW = $clog2(DEPTH);
    localparam logic signed [16:0] C_HI = 17'((1 << (CW - 1)) - 1);
    localparam logic signed [16:0] C_LO = -C_HI - 17'sd1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_LINE,
        S_DRAIN,
        S_READ,
        S_RWAIT,
        S_DONE
    } t_state;

    function automatic logic signed [CW-1:0] sat(input logic signed [IN_COORD_W-1:0] v);
        logic signed [16:0] e;
        e = 17'(v);
        if (e > C_HI) e = C_HI;
        if (e < C_LO) e = C_LO;
        return CW'(e);
    endfunction

    t_state           r_state;
    logic [AW-1:0]    r_clr_addr;
    logic [AW-1:0]    r_rd_addr;
    logic             r_rd_ok;
    logic             r_ink;
    logic [1:0]       r_op;
    logic [7:0]       r_res;
    logic             r_out_valid;
    logic [1:0]       r_out_op;
    logic [7:0]       r_out_byte;

    logic             r_b_valid;
    logic [AW-1:0]    r_b_addr;
    logic [7:0]       r_b_mask;
    logic             r_w_valid;
    logic [AW-1:0]    r_w_addr;
    logic [7:0]       r_w_data;

    logic             accept;
    logic             w_start;
    t_walk_stat       w_stat;
    logic signed [CW-1:0] pix_x, pix_y;
    logic             on_screen;
    logic [AW-1:0]    a_addr;
    logic [7:0]       rdata;
    logic [7:0]       b_old;
    logic [7:0]       b_new;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic [AW-1:0]    rd_addr;
    logic             clearing;

    assign accept = i_in_valid && !o_in_stall;
    assign w_start = accept && (i_op == OP_LINE);

    flr_walker #(
        .CW(CW)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ax    (sat(i_start_x)),
        .i_ay    (sat(i_start_y)),
        .i_bx    (sat(i_end_x)),
        .i_by    (sat(i_end_y)),
        .o_stat  (w_stat),
        .o_pix_x (pix_x),
        .o_pix_y (pix_y)
    );

    always_comb begin
        on_screen = (int'(pix_x) >= 0) && (int'(pix_x) < SCREEN_W)
                 && (int'(pix_y) >= 0) && (int'(pix_y) < SCREEN_H);
        a_addr = AW'(pix_x) + AW'(pix_y >>> 3) * AW'(SCREEN_W);
        b_old = (r_w_valid && (r_w_addr == r_b_addr)) ? r_w_data : rdata;
        b_new = r_ink ? (b_old | r_b_mask) : (b_old & ~r_b_mask);
        clearing = (r_state == S_INIT) || (r_state == S_CLEAR);
        wr_en = clearing || r_b_valid;
        wr_addr = clearing ? r_clr_addr : r_b_addr;
        wr_data = clearing ? 8'h00 : b_new;
        rd_addr = (r_state == S_READ) ? r_rd_addr : a_addr;
    end

    flr_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_w_valid <= 1'b0;
        end else begin
            r_b_valid <= w_stat.pix_valid && on_screen;
            r_b_addr <= a_addr;
            r_b_mask <= 8'(1) << pix_y[2:0];
            r_w_valid <= r_b_valid;
            r_w_addr <= r_b_addr;
            r_w_data <= b_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_clr_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state != S_DONE) && o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT, S_CLEAR: begin
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_clr_addr <= '0;
                        r_state <= (r_state == S_INIT) ? S_IDLE : S_DONE;
                    end else begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op <= i_op;
                        r_ink <= i_ink;
                        r_res <= 8'h00;
                        r_rd_addr <= AW'(i_byte_index);
                        r_rd_ok <= int'(i_byte_index) < DEPTH;
                        case (i_op)
                            OP_CLEAR: r_state <= S_CLEAR;
                            OP_LINE:  r_state <= S_LINE;
                            OP_READ:  r_state <= S_READ;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_LINE: begin
                    if (w_stat.pix_valid && w_stat.last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_READ: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    r_res <= r_rd_ok ? rdata : 8'h00;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_op <= r_op;
                        r_out_byte <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_served_op = r_out_op;
    assign o_read_byte = r_out_byte;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !wr_en)
        else $error("store written while idle");

    a_pix_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.pix_valid |-> (r_state == S_LINE))
        else $error("walker pixel outside line op");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside done state");

    a_fwd_only_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w_valid |-> $past(r_b_valid))
        else $error("forward entry without a preceding write");

endmodule
